// ===== rtl/cfla_pkg.sv =====
// shared types and codes of the chained free-list block allocator
package cfla_pkg;

  // operation codes of an input item
  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_REJECTED = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SLOT_WR,
    ST_WIPE,
    ST_LINK_WR,
    ST_DONE
  } state_e;

  // input item
  typedef struct packed {
    logic       operation;
    logic [7:0] block_number;
  } req_t;

  // result item
  typedef struct packed {
    logic [7:0] granted_block;
    logic [1:0] status;
  } rsp_t;

endpackage

// ===== rtl/cfla_ram.sv =====
// generic single-port-write ram with registered read
module cfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cfla_blk_mod.sv =====
// reduces an 8-bit block number modulo the block count through a constant table
module cfla_blk_mod #(
  parameter int unsigned BLOCK_COUNT = 256,
  parameter int unsigned BIDX_W      = 8
) (
  input  logic [7:0]        value_i,
  output logic [BIDX_W-1:0] block_o
);

  logic [BIDX_W-1:0] blk_tbl [256];

  // one constant entry per possible value
  for (genvar k = 0; k < 256; k++) begin : g_tbl
    localparam int unsigned Rem = k % BLOCK_COUNT;
    assign blk_tbl[k] = BIDX_W'(Rem);
  end

  assign block_o = blk_tbl[value_i];

endmodule

// ===== rtl/chained_free_list_block_allocator.sv =====
// Chained free-list block allocator. The free list lives inside free blocks of a slot
// store (one ram, one access per cycle); each block holds SLOTS_PER_BLOCK 8-bit block
// numbers and its last slot links to the next list block. After reset the block runs a
// clearing pass over all min(BLOCK_COUNT,256)*SLOTS_PER_BLOCK store entries (2048 by
// default) with in_stall_o high. One item is handled at a time: the head block is scanned
// one slot per cycle through the ram. An allocate clears the slot that it hands out, or
// hands out the head block itself when that is empty. A release that has to clear a block
// (its link slot filled, or a full head block) also wipes the released block, and a
// release into an empty list only wipes it. Rejected releases and allocates on an empty
// list go straight to the done state. A finished result sits in an output register, so
// the next item is taken while the previous result waits; a result that finds that
// register still stalled waits in the done state.
module chained_free_list_block_allocator #(
  parameter int unsigned BLOCK_COUNT     = 256,
  parameter int unsigned SLOTS_PER_BLOCK = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cfla_pkg::req_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cfla_pkg::rsp_t  out_item_o
);

  localparam int unsigned UsedBlocks = (BLOCK_COUNT < 256) ? BLOCK_COUNT : 256;
  localparam int unsigned BIDX_W     = $clog2(UsedBlocks);
  localparam int unsigned DEPTH      = UsedBlocks * SLOTS_PER_BLOCK;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned SLOT_W     = $clog2(SLOTS_PER_BLOCK);
  localparam int unsigned CNT_W      = $clog2(SLOTS_PER_BLOCK + 1);
  localparam logic [SLOT_W-1:0] LinkSlot  = SLOT_W'(SLOTS_PER_BLOCK - 1);
  localparam logic [CNT_W-1:0]  SlotCount = CNT_W'(SLOTS_PER_BLOCK);
  localparam logic [ADDR_W-1:0] LastAddr  = ADDR_W'(DEPTH - 1);

  cfla_pkg::state_e  state_q, state_d;
  logic              op_q, op_d;
  logic [BIDX_W-1:0] blk_q, blk_d;
  logic [BIDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [SLOT_W-1:0] chk_idx_q, chk_idx_d;
  logic [7:0]        hit_val_q, hit_val_d;
  logic              link_q, link_d;
  logic [7:0]        grant_q, grant_d;
  logic [1:0]        status_q, status_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  cfla_pkg::rsp_t    out_item_q, out_item_d;

  logic [BIDX_W-1:0] in_blk;
  logic [BIDX_W-1:0] hit_blk;
  logic [BIDX_W-1:0] addr_blk;
  logic [SLOT_W-1:0] addr_slot;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic              scan_hit;
  logic              in_accept;

  // block number reduction for the incoming item and for a found link
  cfla_blk_mod #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BIDX_W      (BIDX_W)
  ) u_in_mod (
    .value_i (in_item_i.block_number),
    .block_o (in_blk)
  );

  cfla_blk_mod #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BIDX_W      (BIDX_W)
  ) u_hit_mod (
    .value_i (hit_val_q),
    .block_o (hit_blk)
  );

  // slot store
  cfla_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // shared address unit: block times slot count plus slot, or the clear counter while clearing
  always_comb begin
    addr_blk  = head_q;
    addr_slot = '0;
    case (state_q)
      cfla_pkg::ST_SCAN: begin
        addr_blk  = head_q;
        addr_slot = (idx_q < SlotCount) ? idx_q[SLOT_W-1:0] : LinkSlot;
      end
      cfla_pkg::ST_SLOT_WR: begin
        addr_blk  = head_q;
        addr_slot = chk_idx_q;
      end
      cfla_pkg::ST_WIPE: begin
        addr_blk  = blk_q;
        addr_slot = idx_q[SLOT_W-1:0];
      end
      cfla_pkg::ST_LINK_WR: begin
        addr_blk  = blk_q;
        addr_slot = LinkSlot;
      end
      default: begin
        addr_blk  = head_q;
        addr_slot = '0;
      end
    endcase
    if (state_q == cfla_pkg::ST_CLEAR) begin
      mem_addr = clr_q;
    end else begin
      mem_addr = ADDR_W'(addr_blk) * ADDR_W'(SLOTS_PER_BLOCK) + ADDR_W'(addr_slot);
    end
  end

  // scan hit: nonzero slot for allocate, empty slot for release
  assign scan_hit = (op_q == cfla_pkg::OP_ALLOCATE) ? (mem_rdata != 8'd0)
                                                     : (mem_rdata == 8'd0);

  assign in_stall_o = (state_q != cfla_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // state register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfla_pkg::ST_CLEAR;
      op_q        <= cfla_pkg::OP_ALLOCATE;
      blk_q       <= '0;
      head_q      <= '0;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      hit_val_q   <= '0;
      link_q      <= 1'b0;
      grant_q     <= '0;
      status_q    <= cfla_pkg::STAT_OK;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      blk_q       <= blk_d;
      head_q      <= head_d;
      idx_q       <= idx_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      hit_val_q   <= hit_val_d;
      link_q      <= link_d;
      grant_q     <= grant_d;
      status_q    <= status_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  // sequencer: next state, store access and result
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    blk_d       = blk_q;
    head_d      = head_q;
    idx_d       = idx_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    hit_val_d   = hit_val_q;
    link_d      = link_q;
    grant_d     = grant_q;
    status_d    = status_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_wdata   = 8'd0;

    case (state_q)
      // zero the whole store after reset
      cfla_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + ADDR_W'(1);
        if (clr_q == LastAddr) begin
          state_d = cfla_pkg::ST_IDLE;
        end
      end

      // take an item and pick the path
      cfla_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_d      = in_item_i.operation;
          blk_d     = in_blk;
          grant_d   = 8'd0;
          status_d  = cfla_pkg::STAT_OK;
          idx_d     = '0;
          chk_vld_d = 1'b0;
          link_d    = 1'b0;
          if (in_item_i.operation == cfla_pkg::OP_ALLOCATE) begin
            if (head_q == '0) begin
              status_d = cfla_pkg::STAT_NO_FREE;
              state_d  = cfla_pkg::ST_DONE;
            end else begin
              state_d = cfla_pkg::ST_SCAN;
            end
          end else begin
            if (in_blk == '0) begin
              status_d = cfla_pkg::STAT_REJECTED;
              state_d  = cfla_pkg::ST_DONE;
            end else if (head_q == '0) begin
              head_d  = in_blk;
              state_d = cfla_pkg::ST_WIPE;
            end else begin
              state_d = cfla_pkg::ST_SCAN;
            end
          end
        end
      end

      // read one slot per cycle, check the slot read the cycle before
      cfla_pkg::ST_SCAN: begin
        if (idx_q < SlotCount) begin
          idx_d     = idx_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q[SLOT_W-1:0];
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          if (scan_hit) begin
            hit_val_d = mem_rdata;
            chk_idx_d = chk_idx_q;
            state_d   = cfla_pkg::ST_SLOT_WR;
          end else if (chk_idx_q == LinkSlot) begin
            if (op_q == cfla_pkg::OP_ALLOCATE) begin
              // head block is empty: hand out the block itself
              grant_d = 8'(head_q);
              head_d  = '0;
              state_d = cfla_pkg::ST_DONE;
            end else begin
              // head block full: freed block becomes the new head
              idx_d   = '0;
              link_d  = 1'b1;
              state_d = cfla_pkg::ST_WIPE;
            end
          end
        end
      end

      // update the found slot
      cfla_pkg::ST_SLOT_WR: begin
        mem_we = 1'b1;
        state_d = cfla_pkg::ST_DONE;
        if (op_q == cfla_pkg::OP_ALLOCATE) begin
          mem_wdata = 8'd0;
          if (chk_idx_q == LinkSlot) begin
            grant_d = 8'(head_q);
            head_d  = hit_blk;
          end else begin
            grant_d = hit_val_q;
          end
        end else begin
          mem_wdata = 8'(blk_q);
          if (chk_idx_q == LinkSlot) begin
            idx_d   = '0;
            link_d  = 1'b0;
            state_d = cfla_pkg::ST_WIPE;
          end
        end
      end

      // zero the released block, one slot per cycle
      cfla_pkg::ST_WIPE: begin
        mem_we = 1'b1;
        idx_d  = idx_q + CNT_W'(1);
        if (idx_q[SLOT_W-1:0] == LinkSlot) begin
          state_d = link_q ? cfla_pkg::ST_LINK_WR : cfla_pkg::ST_DONE;
        end
      end

      // link the new head block to the old one
      cfla_pkg::ST_LINK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = 8'(head_q);
        head_d    = blk_q;
        state_d   = cfla_pkg::ST_DONE;
      end

      // hand the result to the output register once it is free
      cfla_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_item_d.granted_block = grant_q;
          out_item_d.status        = status_q;
          state_d                  = cfla_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cfla_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // the store is only written while an item or the clearing pass is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfla_pkg::ST_IDLE || state_q == cfla_pkg::ST_DONE) |-> !mem_we)
    else $error("slot store written outside an operation");

  // a new result only comes out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> (state_q == cfla_pkg::ST_DONE))
    else $error("result loaded outside done state");

  // the scan index never runs past the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfla_pkg::ST_SCAN) |-> (idx_q <= SlotCount))
    else $error("scan index out of range");

  // a failed item never grants a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != cfla_pkg::STAT_OK)
      |-> (out_item_q.granted_block == 8'd0))
    else $error("block granted with error status");

  // a released block sets the head only when it is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfla_pkg::ST_LINK_WR) |=> (head_q != '0))
    else $error("head cleared by a link write");
`endif

endmodule
